@@ hdl/keq_pkg.sv @@
// keq_pkg: shared types and constants for the key event qualifier.
// Holds the request/response payload structs, the config and lane structs.
// No dependencies.
package keq_pkg;

   localparam int KEY_W    = 4;   // key bits carried per request
   localparam int TIMER_W  = 8;   // per-key countdown timers and config registers
   localparam int CSR_IDX_W = 2;
   localparam int STEP_W   = 2;

   // config register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_FIRST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_IVAL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_DELAY   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DC_WINDOW    = 2'd3;

   // config reset values
   localparam logic [TIMER_W-1:0] RST_REPEAT_FIRST = 8'd80;
   localparam logic [TIMER_W-1:0] RST_REPEAT_IVAL  = 8'd10;
   localparam logic [TIMER_W-1:0] RST_LONG_DELAY   = 8'd120;
   localparam logic [TIMER_W-1:0] RST_DC_WINDOW    = 8'd50;

   // double-click sequencer steps
   localparam logic [STEP_W-1:0] STEP_IDLE     = 2'd0;
   localparam logic [STEP_W-1:0] STEP_FIRST    = 2'd1;
   localparam logic [STEP_W-1:0] STEP_RELEASED = 2'd2;
   localparam logic [STEP_W-1:0] STEP_DONE     = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0] raw_keys;
      logic [KEY_W-1:0] dc_clear;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] pressed;
      logic [KEY_W-1:0] rise_edge;
      logic [KEY_W-1:0] fall_edge;
      logic [KEY_W-1:0] auto_repeat;
      logic [KEY_W-1:0] long_press;
      logic [KEY_W-1:0] double_click;
   } rsp_type;

   typedef struct packed {
      logic [TIMER_W-1:0] repeat_first_delay;
      logic [TIMER_W-1:0] repeat_interval;
      logic [TIMER_W-1:0] long_press_delay;
      logic [TIMER_W-1:0] double_click_window;
   } cfg_type;

   typedef struct packed {
      logic pressed;
      logic rise_edge;
      logic fall_edge;
      logic auto_repeat;
      logic long_press;
      logic double_click;
   } lane_out_type;

endpackage

@@ hdl/keq_lane.sv @@
// keq_lane: per-key event core (debounce, edges, auto-repeat, long press,
// double-click sequencer). State advances once per accepted request.
// Depends on keq_pkg.
module keq_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  raw_key,
   input  logic                  dc_clr,
   input  keq_pkg::cfg_type      cfg,
   output keq_pkg::lane_out_type result
);

   logic                         prev_sample_ff, prev_sample_in;
   logic                         prev_deb_ff, prev_deb_in;
   logic                         first_done_ff, first_done_in;
   logic                         long_en_ff, long_en_in;
   logic                         dc_ff, dc_in;
   logic [keq_pkg::TIMER_W-1:0]  repeat_ff, repeat_in;
   logic [keq_pkg::TIMER_W-1:0]  hold_ff, hold_in;
   logic [keq_pkg::TIMER_W-1:0]  window_ff, window_in;
   logic [keq_pkg::STEP_W-1:0]   step_ff, step_in;

   logic                         sample, cur, rise, fall, rep, lng;
   logic [keq_pkg::TIMER_W-1:0]  repeat_dec, hold_dec, window_dec;

   assign sample     = ~raw_key;
   assign cur        = prev_sample_ff & sample;
   assign rise       = ~prev_deb_ff & cur;
   assign fall       = prev_deb_ff & ~cur;
   assign repeat_dec = (repeat_ff != '0) ? repeat_ff - 1'b1 : repeat_ff;
   assign hold_dec   = (hold_ff != '0) ? hold_ff - 1'b1 : hold_ff;
   assign window_dec = (window_ff != '0) ? window_ff - 1'b1 : window_ff;

   always_comb begin
      prev_sample_in = sample;
      prev_deb_in    = cur;
      first_done_in  = first_done_ff;
      long_en_in     = long_en_ff;
      repeat_in      = repeat_dec;
      hold_in        = hold_dec;
      window_in      = window_dec;
      step_in        = step_ff;
      dc_in          = dc_ff & ~dc_clr;   // host clear lands before this tick's set
      rep            = 1'b0;
      lng            = 1'b0;

      if (cur) begin
         if (!first_done_ff) begin
            first_done_in = 1'b1;
            rep           = 1'b1;
            repeat_in     = cfg.repeat_first_delay;
         end else if (repeat_dec == '0) begin
            rep       = 1'b1;
            repeat_in = cfg.repeat_interval;
         end
         if (hold_dec == '0 && long_en_ff) begin
            lng        = 1'b1;
            long_en_in = 1'b0;
         end
      end else begin
         first_done_in = 1'b0;
         hold_in       = cfg.long_press_delay;
         long_en_in    = 1'b1;
      end

      case (step_ff)
         keq_pkg::STEP_IDLE: begin
            if (rise) begin
               step_in   = keq_pkg::STEP_FIRST;
               window_in = cfg.double_click_window;
            end
         end
         keq_pkg::STEP_FIRST: begin
            if (fall) begin
               step_in   = keq_pkg::STEP_RELEASED;
               window_in = cfg.double_click_window;
            end
            // checked after the reload, so a zero window aborts at once
            if (window_in == '0) step_in = keq_pkg::STEP_IDLE;
         end
         keq_pkg::STEP_RELEASED: begin
            if (rise) step_in = keq_pkg::STEP_DONE;
            if (window_dec == '0) step_in = keq_pkg::STEP_IDLE;
         end
         default: begin
            dc_in   = 1'b1;
            step_in = keq_pkg::STEP_IDLE;
         end
      endcase
   end

   assign result.pressed      = cur;
   assign result.rise_edge    = rise;
   assign result.fall_edge    = fall;
   assign result.auto_repeat  = rep;
   assign result.long_press   = lng;
   assign result.double_click = dc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff <= 1'b0;
         prev_deb_ff    <= 1'b0;
         first_done_ff  <= 1'b0;
         long_en_ff     <= 1'b0;
         dc_ff          <= 1'b0;
         repeat_ff      <= '0;
         hold_ff        <= '0;
         window_ff      <= '0;
         step_ff        <= keq_pkg::STEP_IDLE;
      end else if (accept) begin
         prev_sample_ff <= prev_sample_in;
         prev_deb_ff    <= prev_deb_in;
         first_done_ff  <= first_done_in;
         long_en_ff     <= long_en_in;
         dc_ff          <= dc_in;
         repeat_ff      <= repeat_in;
         hold_ff        <= hold_in;
         window_ff      <= window_in;
         step_ff        <= step_in;
      end
   end

endmodule

@@ hdl/keq_merge.sv @@
// keq_merge: gathers lane results into the response word and holds it in an
// output register backed by a one-entry skid register.
// Depends on keq_pkg.
module keq_merge #(
   parameter int KEYS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  keq_pkg::lane_out_type lanes [KEYS],
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output keq_pkg::rsp_type      rsp_data
);

   keq_pkg::rsp_type merged;
   keq_pkg::rsp_type out_ff, out_in, skid_ff, skid_in;
   logic             out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic             main_free;

   // only keys that fit the response word are visible; response bits with no lane read as zero
   for (genvar n = 0; n < keq_pkg::KEY_W; n++) begin : g_bits
      if (n < KEYS) begin : g_lane
         assign merged.pressed[n]      = lanes[n].pressed;
         assign merged.rise_edge[n]    = lanes[n].rise_edge;
         assign merged.fall_edge[n]    = lanes[n].fall_edge;
         assign merged.auto_repeat[n]  = lanes[n].auto_repeat;
         assign merged.long_press[n]   = lanes[n].long_press;
         assign merged.double_click[n] = lanes[n].double_click;
      end else begin : g_zero
         assign merged.pressed[n]      = 1'b0;
         assign merged.rise_edge[n]    = 1'b0;
         assign merged.fall_edge[n]    = 1'b0;
         assign merged.auto_repeat[n]  = 1'b0;
         assign merged.long_press[n]   = 1'b0;
         assign merged.double_click[n] = 1'b0;
      end
   end

   assign main_free = ~out_valid_ff | rsp_ready;
   assign req_ready = ~skid_valid_ff;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = merged;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = merged;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ hdl/key_event_qualifier.sv @@
// key_event_qualifier: scan-tick key event qualifier, one lane per key.
// A response is registered straight into the output register when that is free, else it waits in the skid register.
// Throughput: one request per cycle while req_ready is high; the per-key lanes update once per accepted request.
// Stalls: while rsp_ready is low the skid register takes one more request, then
// req_ready drops; it rises again in the cycle after rsp_ready returns.
// Reset (synchronous): config registers return to 80/10/120/50, all key state clears.
// Depends on keq_pkg, keq_lane, keq_merge.
module key_event_qualifier #(
   parameter int KEYS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  keq_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output keq_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_en,
   input  logic [keq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [keq_pkg::TIMER_W-1:0]    csr_wdata
);

   keq_pkg::cfg_type      cfg_ff, cfg_in;
   keq_pkg::lane_out_type lanes [KEYS];
   logic                  accept;

   assign accept = req_valid & req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            keq_pkg::CSR_REPEAT_FIRST: cfg_in.repeat_first_delay  = csr_wdata;
            keq_pkg::CSR_REPEAT_IVAL:  cfg_in.repeat_interval     = csr_wdata;
            keq_pkg::CSR_LONG_DELAY:   cfg_in.long_press_delay    = csr_wdata;
            keq_pkg::CSR_DC_WINDOW:    cfg_in.double_click_window = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_first_delay  <= keq_pkg::RST_REPEAT_FIRST;
         cfg_ff.repeat_interval     <= keq_pkg::RST_REPEAT_IVAL;
         cfg_ff.long_press_delay    <= keq_pkg::RST_LONG_DELAY;
         cfg_ff.double_click_window <= keq_pkg::RST_DC_WINDOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   for (genvar n = 0; n < KEYS; n++) begin : g_lane
      logic raw_key, dc_clr;
      // keys beyond the request word see a low pin (pressed) and no clear
      if (n < keq_pkg::KEY_W) begin : g_in
         assign raw_key = req_data.raw_keys[n];
         assign dc_clr  = req_data.dc_clear[n];
      end else begin : g_pad
         assign raw_key = 1'b0;
         assign dc_clr  = 1'b0;
      end

      keq_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .accept  (accept),
         .raw_key (raw_key),
         .dc_clr  (dc_clr),
         .cfg     (cfg_ff),
         .result  (lanes[n])
      );
   end

   keq_merge #(
      .KEYS (KEYS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .lanes     (lanes),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // skid only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("skid full while output register empty");

   // after an accepted request a response is always valid in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");

   a_edges_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.rise_edge & rsp_data.fall_edge) == '0))
      else $error("rise and fall on the same key");

   a_events_while_pressed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_data.rise_edge | rsp_data.auto_repeat | rsp_data.long_press)
                      & ~rsp_data.pressed) == '0))
      else $error("press event on a released key");

endmodule
